>>> rtl/core/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// shared types and constants of the set-associative tag lookup with lru
// ----------------------------------------------------------------------------
package sacl_pkg;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [3:0] ways_in_use;
    logic [3:0] offset_bits;
    logic [3:0] index_bits;
  } cfg_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_WAYS   = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_INDEX  = 2'd2;

  // register reset values
  localparam logic [3:0] WAYS_RST   = 4'd8;
  localparam logic [3:0] OFFSET_RST = 4'd4;
  localparam logic [3:0] INDEX_RST  = 4'd8;

  // line number width: index_bits is at most 15
  localparam int LINE_W = 15;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SPLIT,
    S_LOOK,
    S_DECIDE
  } state_e;

endpackage

>>> rtl/core/sacl_addr_split.sv
// ----------------------------------------------------------------------------
// sacl_addr_split
// splits an address into tag and set; the set is the masked line number
// reduced modulo SET_COUNT by a reciprocal multiply and one correction
// ----------------------------------------------------------------------------
module sacl_addr_split #(
  parameter int ADDR_WIDTH = 32,
  parameter int SET_COUNT  = 256,
  parameter int TAG_W      = 32,
  parameter int SET_W      = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        address_i,
  input  sacl_pkg::cfg_t     cfg_i,
  output logic               done_o,
  output logic [SET_W-1:0]   set_o,
  output logic [TAG_W-1:0]   tag_o
);
  import sacl_pkg::*;

  localparam int EFF_AW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
  localparam longint unsigned RECIP_L = (64'd1 << 30) / SET_COUNT;
  localparam logic [30:0] RECIP = 31'(RECIP_L);
  localparam logic [12:0] SETS_C = 13'(SET_COUNT);

  logic [EFF_AW-1:0] addr_m;
  logic [EFF_AW-1:0] line_sh;
  logic [EFF_AW-1:0] tag_sh;
  logic [4:0]        tag_amt;
  logic [LINE_W-1:0] line_mask;
  logic [LINE_W-1:0] line_d, line_q;
  logic [TAG_W-1:0]  tag_q;
  logic [45:0]       prod_q;
  logic [15:0]       quo;
  logic [28:0]       qn_full;
  logic [15:0]       qn_q;
  logic [15:0]       rem;
  logic [15:0]       rem_c;
  logic [2:0]        v_q;

  always_comb begin
    addr_m    = address_i[EFF_AW-1:0];
    line_sh   = addr_m >> cfg_i.offset_bits;
    line_mask = LINE_W'((16'd1 << cfg_i.index_bits) - 16'd1);
    line_d    = LINE_W'(line_sh) & line_mask;
    tag_amt   = 5'(cfg_i.offset_bits) + 5'(cfg_i.index_bits);
    tag_sh    = addr_m >> tag_amt;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      line_q <= line_d;
      tag_q  <= TAG_W'(tag_sh);
    end
  end

  // quotient estimate is exact or one low
  always_comb begin
    quo     = prod_q[45:30];
    qn_full = 29'(quo) * 29'(SETS_C);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 46'(line_q) * 46'(RECIP);
    qn_q   <= qn_full[15:0];
  end

  always_comb begin
    rem = {1'b0, line_q} - qn_q;
    if (rem >= 16'(SETS_C)) begin
      rem_c = rem - 16'(SETS_C);
    end else begin
      rem_c = rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], start_i};
    end
  end

  assign done_o = v_q[2];
  assign set_o  = rem_c[SET_W-1:0];
  assign tag_o  = tag_q;

endmodule

>>> rtl/core/sacl_way_store.sv
// ----------------------------------------------------------------------------
// sacl_way_store
// tag and stamp memories, one row per set; the tag row also carries the
// fill count, which a clearing pass zeroes after reset
// ----------------------------------------------------------------------------
module sacl_way_store #(
  parameter int MAX_WAYS  = 8,
  parameter int SET_COUNT = 256,
  parameter int TAG_W     = 32,
  parameter int FILL_W    = 4,
  parameter int SET_W     = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rd_en_i,
  input  logic [SET_W-1:0]                   rd_set_i,
  input  logic                               wr_en_i,
  input  logic [SET_W-1:0]                   wr_set_i,
  input  logic [MAX_WAYS-1:0][TAG_W-1:0]     wr_tags_i,
  input  logic [MAX_WAYS-1:0][31:0]          wr_stamps_i,
  input  logic [FILL_W-1:0]                  wr_fill_i,
  output logic [MAX_WAYS-1:0][TAG_W-1:0]     rd_tags_o,
  output logic [MAX_WAYS-1:0][31:0]          rd_stamps_o,
  output logic [FILL_W-1:0]                  rd_fill_o,
  output logic                               clr_busy_o
);
  import sacl_pkg::*;

  localparam int TROW_W = FILL_W + MAX_WAYS * TAG_W;
  localparam int SROW_W = MAX_WAYS * 32;

  logic [TROW_W-1:0] tag_mem   [SET_COUNT];
  logic [SROW_W-1:0] stamp_mem [SET_COUNT];
  logic [TROW_W-1:0] trow_q;
  logic [SROW_W-1:0] srow_q;
  logic [SET_W-1:0]  clr_cnt_q;
  logic              clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == SET_W'(SET_COUNT - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      tag_mem[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      tag_mem[wr_set_i] <= {wr_fill_i, wr_tags_i};
    end
    if (rd_en_i) begin
      trow_q <= tag_mem[rd_set_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !clr_busy_q) begin
      stamp_mem[wr_set_i] <= wr_stamps_i;
    end
    if (rd_en_i) begin
      srow_q <= stamp_mem[rd_set_i];
    end
  end

  assign rd_fill_o   = trow_q[TROW_W-1 -: FILL_W];
  assign rd_tags_o   = trow_q[MAX_WAYS*TAG_W-1:0];
  assign rd_stamps_o = srow_q;
  assign clr_busy_o  = clr_busy_q;

endmodule

>>> rtl/core/sacl_way_pick.sv
// ----------------------------------------------------------------------------
// sacl_way_pick
// registers tag matches and ages of one set row, then picks the hit way,
// the next free way or the oldest way
// ----------------------------------------------------------------------------
module sacl_way_pick #(
  parameter int MAX_WAYS = 8,
  parameter int TAG_W    = 32,
  parameter int WAY_W    = 3,
  parameter int FILL_W   = 4
) (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic [MAX_WAYS-1:0][TAG_W-1:0] tags_i,
  input  logic [MAX_WAYS-1:0][31:0]      stamps_i,
  input  logic [FILL_W-1:0]              fill_i,
  input  logic [TAG_W-1:0]               tag_i,
  input  logic [FILL_W-1:0]              ways_i,
  input  logic [31:0]                    clock_i,
  output logic                           hit_o,
  output logic                           fill_o,
  output logic [WAY_W-1:0]               way_o,
  output logic [FILL_W-1:0]              fill_eff_o
);
  import sacl_pkg::*;

  localparam int LV = $clog2(MAX_WAYS);
  localparam int P  = 1 << LV;
  localparam int NN = 2 * P - 1;

  logic [FILL_W-1:0]     fill_eff, fill_eff_q;
  logic [P-1:0]          inuse_p, inuse_q;
  logic [P-1:0][31:0]    stamps_p;
  logic [P-1:0][31:0]    age_q;
  logic [MAX_WAYS-1:0]   match, match_q;
  logic                  room_q;
  logic [WAY_W-1:0]      hit_way;
  logic                  nv [NN];
  logic [31:0]           na [NN];
  logic [WAY_W-1:0]      nw [NN];
  logic                  take_r;

  always_comb begin
    fill_eff = (fill_i > ways_i) ? ways_i : fill_i;
    stamps_p = '0;
    stamps_p[MAX_WAYS-1:0] = stamps_i;
    for (int i = 0; i < P; i++) begin
      inuse_p[i] = (i < MAX_WAYS) && (FILL_W'(i) < fill_eff);
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      match[i] = inuse_p[i] && (tags_i[i] == tag_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      fill_eff_q <= fill_eff;
      room_q     <= fill_eff < ways_i;
      match_q    <= match;
      inuse_q    <= inuse_p;
      for (int i = 0; i < P; i++) begin
        age_q[i] <= clock_i - stamps_p[i];
      end
    end
  end

  // lowest matching way wins
  always_comb begin
    hit_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_way = WAY_W'(i);
      end
    end
  end

  // oldest-age tree, left child keeps ties so lower ways win
  always_comb begin
    take_r = 1'b0;
    for (int i = 0; i < P; i++) begin
      nv[P-1+i] = inuse_q[i];
      na[P-1+i] = age_q[i];
      nw[P-1+i] = WAY_W'(i);
    end
    for (int n = P - 2; n >= 0; n--) begin
      take_r = nv[2*n+2] && (!nv[2*n+1] || (na[2*n+2] > na[2*n+1]));
      nv[n]  = nv[2*n+1] || nv[2*n+2];
      na[n]  = take_r ? na[2*n+2] : na[2*n+1];
      nw[n]  = take_r ? nw[2*n+2] : nw[2*n+1];
    end
  end

  always_comb begin
    hit_o      = |match_q;
    fill_o     = !hit_o && room_q;
    fill_eff_o = fill_eff_q;
    if (hit_o) begin
      way_o = hit_way;
    end else if (room_q) begin
      way_o = WAY_W'(fill_eff_q);
    end else begin
      way_o = nw[0];
    end
  end

endmodule

>>> rtl/core/set_assoc_cache_lru_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup
// tag lookup of a set-associative cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// One input beat carries a byte address; one output beat reports hit or
// miss, the way that hit, was filled or was replaced, and saturating running
// hit and access counts. Both channels use valid/stall. Three 4-bit
// registers sit on an APB-style port at byte addresses 0, 4 and 8: ways in
// use, offset bits and index bits; write them only while the block is idle.
// A new address is taken on the cycle a result is committed, so an access
// is not taken before the previous result is committed. The set reduction
// is line times a reciprocal, then quotient times the set count, then one
// correcting subtract; then come the set-row memory read and the
// compare/oldest-way pick that writes the row back. After reset a clearing
// pass zeroes the per-set fill counts and no address is taken until it ends;
// register writes are served throughout. A stalled output beat holds in
// its register; a new address is still taken, but its result waits until
// the held beat leaves.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup #(
  parameter int MAX_WAYS   = 8,
  parameter int SET_COUNT  = 256,
  parameter int ADDR_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [2:0]  way_used_o,
  output logic [31:0] hits_so_far_o,
  output logic [31:0] accesses_so_far_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sacl_pkg::*;

  localparam int EFF_AW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
  localparam int TAG_W  = EFF_AW;
  localparam int SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int FILL_W = $clog2(MAX_WAYS + 1);
  localparam int WAYX_W = (WAY_W > 3) ? WAY_W : 3;

  state_e state_q, state_d;
  cfg_t   cfg_q;

  logic                           apb_wr;
  logic                           in_acc;
  logic                           out_free;
  logic                           split_start;
  logic                           split_done;
  logic [SET_W-1:0]               split_set;
  logic [TAG_W-1:0]               split_tag;
  logic                           rd_en;
  logic                           pick_load;
  logic                           commit;
  logic                           clr_busy;
  logic [SET_W-1:0]               set_q;
  logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tags, wr_tags;
  logic [MAX_WAYS-1:0][31:0]      rd_stamps, wr_stamps;
  logic [FILL_W-1:0]              rd_fill, wr_fill;
  logic [4:0]                     ways5;
  logic [FILL_W-1:0]              ways_c;
  logic                           pick_hit;
  logic                           pick_fill;
  logic [WAY_W-1:0]               pick_way;
  logic [FILL_W-1:0]              pick_fill_eff;
  logic [WAYX_W-1:0]              way_x;
  logic [31:0]                    clock_q;
  logic [31:0]                    hit_cnt_q, hit_cnt_d;
  logic [31:0]                    acc_cnt_q, acc_cnt_d;
  logic                           out_valid_q;
  logic                           out_hit_q;
  logic [2:0]                     out_way_q;
  logic [31:0]                    out_hits_q;
  logic [31:0]                    out_acc_q;

  // configuration port
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ways_in_use <= WAYS_RST;
      cfg_q.offset_bits <= OFFSET_RST;
      cfg_q.index_bits  <= INDEX_RST;
    end else if (apb_wr) begin
      unique case (paddr[3:2])
        REG_WAYS:   cfg_q.ways_in_use <= pwdata[3:0];
        REG_OFFSET: cfg_q.offset_bits <= pwdata[3:0];
        REG_INDEX:  cfg_q.index_bits  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WAYS:   prdata = {28'd0, cfg_q.ways_in_use};
      REG_OFFSET: prdata = {28'd0, cfg_q.offset_bits};
      REG_INDEX:  prdata = {28'd0, cfg_q.index_bits};
      default:    prdata = '0;
    endcase
  end

  // zero ways acts as one, too many acts as the maximum
  always_comb begin
    ways5 = {1'b0, cfg_q.ways_in_use};
    if (ways5 == 5'd0) begin
      ways_c = FILL_W'(1);
    end else if (ways5 > 5'(MAX_WAYS)) begin
      ways_c = FILL_W'(MAX_WAYS);
    end else begin
      ways_c = FILL_W'(ways5);
    end
  end

  // sequencer
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (!clr_busy) state_d = S_IDLE;
      S_IDLE:   if (in_valid_i) state_d = S_SPLIT;
      S_SPLIT:  if (split_done) state_d = S_LOOK;
      S_LOOK:   state_d = S_DECIDE;
      S_DECIDE: begin
        if (out_free) begin
          state_d = in_valid_i ? S_SPLIT : S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    pick_load  = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      S_CLEAR:  ;
      S_IDLE:   in_stall_o = 1'b0;
      S_SPLIT:  rd_en = split_done;
      S_LOOK:   pick_load = 1'b1;
      S_DECIDE: begin
        in_stall_o = !out_free;
        commit     = out_free;
      end
      default:  ;
    endcase
    in_acc      = in_valid_i && !in_stall_o;
    split_start = in_acc;
  end

  sacl_addr_split #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .SET_COUNT  (SET_COUNT),
    .TAG_W      (TAG_W),
    .SET_W      (SET_W)
  ) u_split (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (split_start),
    .address_i (address_i),
    .cfg_i     (cfg_q),
    .done_o    (split_done),
    .set_o     (split_set),
    .tag_o     (split_tag)
  );

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      set_q <= split_set;
    end
  end

  sacl_way_store #(
    .MAX_WAYS  (MAX_WAYS),
    .SET_COUNT (SET_COUNT),
    .TAG_W     (TAG_W),
    .FILL_W    (FILL_W),
    .SET_W     (SET_W)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (rd_en),
    .rd_set_i    (split_set),
    .wr_en_i     (commit),
    .wr_set_i    (set_q),
    .wr_tags_i   (wr_tags),
    .wr_stamps_i (wr_stamps),
    .wr_fill_i   (wr_fill),
    .rd_tags_o   (rd_tags),
    .rd_stamps_o (rd_stamps),
    .rd_fill_o   (rd_fill),
    .clr_busy_o  (clr_busy)
  );

  sacl_way_pick #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W),
    .WAY_W    (WAY_W),
    .FILL_W   (FILL_W)
  ) u_pick (
    .clk_i      (clk_i),
    .load_i     (pick_load),
    .tags_i     (rd_tags),
    .stamps_i   (rd_stamps),
    .fill_i     (rd_fill),
    .tag_i      (split_tag),
    .ways_i     (ways_c),
    .clock_i    (clock_q),
    .hit_o      (pick_hit),
    .fill_o     (pick_fill),
    .way_o      (pick_way),
    .fill_eff_o (pick_fill_eff)
  );

  // row write-back: the read row stays in the memory output register
  always_comb begin
    wr_tags   = rd_tags;
    wr_stamps = rd_stamps;
    if (!pick_hit) begin
      wr_tags[pick_way] = split_tag;
    end
    wr_stamps[pick_way] = clock_q;
    wr_fill = pick_fill ? (pick_fill_eff + 1'b1) : rd_fill;
  end

  always_comb begin
    hit_cnt_d = hit_cnt_q;
    acc_cnt_d = acc_cnt_q;
    if (pick_hit && (hit_cnt_q != '1)) begin
      hit_cnt_d = hit_cnt_q + 32'd1;
    end
    if (acc_cnt_q != '1) begin
      acc_cnt_d = acc_cnt_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q   <= '0;
      hit_cnt_q <= '0;
      acc_cnt_q <= '0;
    end else if (commit) begin
      clock_q   <= clock_q + 32'd1;
      hit_cnt_q <= hit_cnt_d;
      acc_cnt_q <= acc_cnt_d;
    end
  end

  // output register
  assign way_x = WAYX_W'(pick_way);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_hit_q  <= pick_hit;
      out_way_q  <= way_x[2:0];
      out_hits_q <= hit_cnt_d;
      out_acc_q  <= acc_cnt_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hit_o             = out_hit_q;
  assign way_used_o        = out_way_q;
  assign hits_so_far_o     = out_hits_q;
  assign accesses_so_far_o = out_acc_q;

  // checks
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> in_stall_o)
    else $error("address taken during clearing pass");

  a_hits_le_accesses : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_cnt_q <= acc_cnt_q)
    else $error("hit count above access count");

  a_way_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> (FILL_W'(pick_way) < ways_c))
    else $error("chosen way beyond ways in use");

  a_hit_way_filled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && pick_hit |-> (FILL_W'(pick_way) < pick_fill_eff))
    else $error("hit on an unfilled way");

endmodule

>>> bench/tb_set_assoc_cache_lru_lookup.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_lookup
// self-checking bench for the set-associative tag lookup with lru replacement
// ----------------------------------------------------------------------------
// Drives byte addresses through the valid/stall input channel and sets the
// three geometry registers over the register port between phases, once the
// pipeline has drained. A tag/age mirror of the cache works out the expected
// hit, way and running counts for every accepted address, and each output
// beat is compared field by field with the oldest pending lookup. Most random
// addresses are drawn from a small hot set of lines and tags, so that hits,
// fills and lru evictions all occur; the rest are fully random.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_lookup;
  import sacl_pkg::*;

  localparam int unsigned NUM_SETS       = 256;
  localparam int unsigned NUM_WAYS       = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  class lru_tag_scoreboard;
    typedef struct {
      logic        hit;
      logic [2:0]  way;
      logic [31:0] hits;
      logic [31:0] accesses;
    } lookup_t;

    logic [31:0] tags [NUM_SETS][NUM_WAYS];
    logic [31:0] stamps [NUM_SETS][NUM_WAYS];
    int unsigned fill_count [NUM_SETS];
    logic [31:0] access_clock;
    logic [31:0] hit_count;
    logic [31:0] access_count;
    int unsigned ways_cfg;
    int unsigned offset_cfg;
    int unsigned index_cfg;
    lookup_t     pending_lookups [$];
    int unsigned mismatch_count;

    function new();
      foreach (fill_count[s]) fill_count[s] = 0;
      access_clock   = '0;
      hit_count      = '0;
      access_count   = '0;
      ways_cfg       = WAYS_RST;
      offset_cfg     = OFFSET_RST;
      index_cfg      = INDEX_RST;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [3:0] val);
      case (idx)
        REG_WAYS:   ways_cfg = val;
        REG_OFFSET: offset_cfg = val;
        REG_INDEX:  index_cfg = val;
        default: ;
      endcase
    endfunction

    // look the address up in the mirror, update it and queue the outcome
    function void note_access(logic [31:0] addr);
      int unsigned ways;
      int unsigned filled;
      int unsigned set_idx;
      int unsigned w;
      logic [63:0] line;
      logic [31:0] tag_v;
      logic [31:0] age;
      logic [31:0] oldest;
      lookup_t     res;
      ways = (ways_cfg == 0) ? 1 : (ways_cfg > NUM_WAYS) ? NUM_WAYS : ways_cfg;
      line = ({32'd0, addr} >> offset_cfg) & ((64'd1 << index_cfg) - 64'd1);
      set_idx = int'(line % NUM_SETS);
      tag_v = 32'({32'd0, addr} >> (offset_cfg + index_cfg));
      filled = (fill_count[set_idx] > ways) ? ways : fill_count[set_idx];
      res.hit = 1'b0;
      w = 0;
      for (int i = 0; i < filled; i++) begin
        if (!res.hit && tags[set_idx][i] == tag_v) begin
          res.hit = 1'b1;
          w = i;
        end
      end
      if (!res.hit) begin
        if (filled < ways) begin
          w = filled;
          fill_count[set_idx] = filled + 1;
        end else begin
          // oldest by wrapping age, ties to the lowest way
          oldest = '0;
          w = 0;
          for (int i = 0; i < filled; i++) begin
            age = access_clock - stamps[set_idx][i];
            if (i == 0 || age > oldest) begin
              oldest = age;
              w = i;
            end
          end
        end
        tags[set_idx][w] = tag_v;
      end
      stamps[set_idx][w] = access_clock;
      access_clock = access_clock + 32'd1;
      if (res.hit && hit_count != '1) hit_count = hit_count + 32'd1;
      if (access_count != '1) access_count = access_count + 32'd1;
      res.way      = 3'(w);
      res.hits     = hit_count;
      res.accesses = access_count;
      pending_lookups.push_back(res);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatch_count++;
    endtask

    task check_result(logic hit, logic [2:0] way, logic [31:0] hits,
                      logic [31:0] accesses);
      lookup_t exp_r;
      if (pending_lookups.size() == 0) begin
        report($sformatf("unexpected beat: hit %0b way %0d hits %0d accesses %0d",
                         hit, way, hits, accesses));
        return;
      end
      exp_r = pending_lookups.pop_front();
      if (hit !== exp_r.hit)
        report($sformatf("hit %0b, expected %0b (access %0d)",
                         hit, exp_r.hit, exp_r.accesses));
      if (way !== exp_r.way)
        report($sformatf("way_used %0d, expected %0d (access %0d)",
                         way, exp_r.way, exp_r.accesses));
      if (hits !== exp_r.hits)
        report($sformatf("hits_so_far %0d, expected %0d (access %0d)",
                         hits, exp_r.hits, exp_r.accesses));
      if (accesses !== exp_r.accesses)
        report($sformatf("accesses_so_far %0d, expected %0d",
                         accesses, exp_r.accesses));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] address_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        hit_o;
  logic [2:0]  way_used_o;
  logic [31:0] hits_so_far_o;
  logic [31:0] accesses_so_far_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lru_tag_scoreboard lru_sb = new();

  int unsigned cur_ways;
  int unsigned cur_off;
  int unsigned cur_idx;
  bit          no_idle;
  int unsigned idle_cycles;

  logic [31:0] directed_addrs [$] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_000F,
    32'h8000_0000, 32'h0000_2000, 32'h0000_3000, 32'h0000_4000, 32'h0000_5000,
    32'h0000_6000, 32'h0000_7000, 32'h0000_0000, 32'h0000_8000, 32'h8000_0000
  };

  set_assoc_cache_lru_lookup i_dut (.*);

  always #4 clk_i = ~clk_i;

  task automatic send_access(input logic [31:0] addr);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i  <= addr;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    lru_sb.note_access(addr);
  endtask

  // always moves at least one edge so no input is driven twice in a step
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (lru_sb.pending_lookups.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'($urandom()), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    lru_sb.set_reg(idx, val);
  endtask

  // hot lines and a handful of tags per phase, with some fully random beats
  function automatic logic [31:0] pick_address(logic [31:0] tag_base);
    int unsigned r;
    int unsigned line;
    int unsigned shift;
    logic [63:0] tag_v;
    logic [63:0] a;
    r = $urandom_range(0, 99);
    if (r < 20) return $urandom();
    shift = cur_off + cur_idx;
    line = $urandom_range(0, 3);
    // lines that alias onto the same set once reduced
    if (r < 35) line += NUM_SETS * $urandom_range(1, 127);
    tag_v = 64'(tag_base) + 64'($urandom_range(0, cur_ways + 3));
    a = (tag_v << shift)
      | ((64'(line) & ((64'd1 << cur_idx) - 64'd1)) << cur_off)
      | (64'($urandom()) & ((64'd1 << cur_off) - 64'd1));
    return a[31:0];
  endfunction

  task automatic run_phase(input logic [3:0] ways, input logic [3:0] off,
                           input logic [3:0] idx, input int unsigned n_items,
                           input bit calm);
    logic [31:0] tag_base;
    drain();
    repeat (8) @(posedge clk_i);
    write_reg(REG_WAYS, ways);
    write_reg(REG_OFFSET, off);
    write_reg(REG_INDEX, idx);
    cur_ways = ways;
    cur_off  = off;
    cur_idx  = idx;
    no_idle  = calm;
    tag_base = $urandom();
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2 && $urandom_range(0, 1) == 1) drain();
      send_access(pick_address(tag_base));
    end
  endtask

  // receiver: hold stall for a random number of cycles after each beat, never when no_idle is set
  initial begin
    int unsigned gap;
    out_stall_i <= 1'b0;
    forever begin
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && !out_stall_i));
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && !out_stall_i)
      lru_sb.check_result(hit_o, way_used_o, hits_so_far_o, accesses_so_far_o);
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("set_assoc_cache_lru_lookup verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    address_i   <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    idle_cycles = 0;
    no_idle     = 1'b0;
    cur_ways    = WAYS_RST;
    cur_off     = OFFSET_RST;
    cur_idx     = INDEX_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: hits on both extremes, fill set 0, then two evictions
    foreach (directed_addrs[i]) send_access(directed_addrs[i]);

    run_phase(4'd1,  4'd0,  4'd0,  55, 1'b0);
    run_phase(4'd15, 4'd12, 4'd8,  55, 1'b1);
    run_phase(4'd0,  4'd15, 4'd15, 55, 1'b0);
    run_phase(4'd3,  4'd2,  4'd9,  55, 1'($urandom_range(0, 1)));
    run_phase(4'd8,  4'd4,  4'd8,  55, 1'b0);
    run_phase(4'd5,  4'd7,  4'd3,  55, 1'($urandom_range(0, 1)));
    run_phase(4'd2,  4'd0,  4'd1,  55, 1'b0);

    drain();
    repeat (10) @(posedge clk_i);
    if (lru_sb.mismatch_count == 0 && lru_sb.pending_lookups.size() == 0) begin
      $display("set_assoc_cache_lru_lookup verification clean");
    end else begin
      $display("set_assoc_cache_lru_lookup verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sacl_pkg.sv
rtl/core/sacl_addr_split.sv
rtl/core/sacl_way_store.sv
rtl/core/sacl_way_pick.sv
rtl/core/set_assoc_cache_lru_lookup.sv
bench/tb_set_assoc_cache_lru_lookup.sv
